@@ rtl/core/fsfls_pkg.sv @@
`timescale 1ns / 1ps

package fsfls_pkg;

    localparam int SLOT_COUNT_DEF        = 256;
    localparam int MAX_PAYLOAD_BYTES_DEF = 8;

    localparam int DATA_W   = 64;
    localparam int SLOT_W   = 8;
    localparam int LEN_W    = 4;
    localparam int STATUS_W = 3;
    localparam int REQ_W    = 2;

    localparam logic [LEN_W-1:0] PAYLOAD_BYTES_RST = 4'd8;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LIVE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD      = 3'd4;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_PAYLOAD_BYTES = '0;

endpackage

@@ rtl/core/fixed_slot_free_list_store_top.sv @@
`timescale 1ns / 1ps

// Record store of SLOT_COUNT fixed-size slots, each holding a live mark, a
// free-list link and up to MAX_PAYLOAD_BYTES payload bytes. Insert reuses the
// most recently erased slot, else appends, else reports full; read, update and
// erase address a slot by index. The cycle a transaction is accepted issues a
// registered read of the slot memory (at the slot, or at the free-list head for
// an insert), and the EXEC state that follows checks the entry and writes it
// back to the slot memory. The input stalls while the block is in EXEC. The
// result sits in an output register, so a new transaction is taken while the
// previous result waits; the write-back holds while an earlier result is still
// stalled. The payload_bytes register at address 0 sets the payload size and
// resets to 8. The slot memory is not cleared after reset.
module fixed_slot_free_list_store_top
    import fsfls_pkg::*;
#(
    parameter int SLOT_COUNT        = SLOT_COUNT_DEF,
    parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [SLOT_W-1:0]       slot,
    input  logic [DATA_W-1:0]       data,
    input  logic [LEN_W-1:0]        length,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [SLOT_W-1:0]       slot_out,
    output logic [DATA_W-1:0]       read_data
);

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int PTR_W   = IDX_W + 1;
    localparam int CMP_W   = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;
    localparam int PL_W    = 8 * MAX_PAYLOAD_BYTES;
    localparam int WORD_W  = 1 + PTR_W + PL_W;

    localparam logic [PTR_W-1:0] SLOT_LIMIT = PTR_W'(SLOT_COUNT);
    localparam logic [LEN_W-1:0] MAX_P      = LEN_W'(MAX_PAYLOAD_BYTES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // slot memory word: {live, next_free, payload}
    logic [WORD_W-1:0]      mem [SLOT_COUNT];
    logic [WORD_W-1:0]      rd_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [WORD_W-1:0]      wr_word;

    logic                   state_reg, state_next;
    logic [LEN_W-1:0]       pbytes_reg;
    logic [PTR_W-1:0]       free_head_reg, free_head_next;
    logic [PTR_W-1:0]       end_reg, end_next;

    logic [REQ_W-1:0]       req_reg;
    logic [CMP_W-1:0]       slot_reg;
    logic [PL_W-1:0]        data_reg;
    logic [LEN_W-1:0]       len_reg;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [SLOT_W-1:0]      slot_out_reg, slot_out_next;
    logic [PL_W-1:0]        rdata_reg, rdata_next;

    logic                   accept;
    logic                   fire;
    logic                   cfg_wr;
    logic [LEN_W-1:0]       p_eff;
    logic [LEN_W-1:0]       rd_len;
    logic [PL_W-1:0]        wmask;
    logic [PL_W-1:0]        rmask;
    logic                   head_empty;
    logic                   in_range;
    logic                   rd_live;
    logic [PTR_W-1:0]       rd_next;
    logic [PL_W-1:0]        rd_payload;
    logic [IDX_W-1:0]       slot_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == REG_PAYLOAD_BYTES) ? APB_DATA_W'(pbytes_reg) : '0;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign fire     = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    assign head_empty = (free_head_reg >= SLOT_LIMIT);

    // insert looks up the free-list head, everything else the addressed slot
    always_comb
    begin
        if (req_type == REQ_INSERT)
            rd_addr = free_head_reg[IDX_W-1:0];
        else
            rd_addr = CMP_W'(slot) >= CMP_W'(SLOT_LIMIT) ? '0 : IDX_W'(CMP_W'(slot));
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_word;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            slot_reg <= CMP_W'(slot);
            data_reg <= data[PL_W-1:0];
            len_reg  <= length;
        end
    end

    assign rd_live    = rd_reg[WORD_W-1];
    assign rd_next    = rd_reg[PL_W +: PTR_W];
    assign rd_payload = rd_reg[PL_W-1:0];
    assign slot_idx   = slot_reg[IDX_W-1:0];
    assign in_range   = slot_reg < CMP_W'(end_reg);

    assign p_eff  = (pbytes_reg > MAX_P) ? MAX_P : pbytes_reg;
    assign rd_len = (len_reg > p_eff) ? p_eff : len_reg;

    always_comb
    begin
        for (int b = 0; b < MAX_PAYLOAD_BYTES; b++)
        begin
            wmask[8*b +: 8] = {8{LEN_W'(b) < len_reg}};
            rmask[8*b +: 8] = {8{LEN_W'(b) < rd_len}};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        end_next       = end_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_idx;
        wr_word        = {1'b1, rd_next, data_reg & wmask};
        status_next    = STATUS_OK;
        slot_out_next  = slot_reg[SLOT_W-1:0];
        rdata_next     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                    case (req_reg)
                        REQ_INSERT:
                        begin
                            slot_out_next = '0;
                            if (len_reg > p_eff)
                                status_next = STATUS_TOO_LONG;
                            else if (!head_empty)
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = free_head_reg[IDX_W-1:0];
                                free_head_next = rd_next;
                                slot_out_next  = SLOT_W'(free_head_reg[IDX_W-1:0]);
                            end
                            else if (end_reg < SLOT_LIMIT)
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = end_reg[IDX_W-1:0];
                                end_next      = end_reg + 1'b1;
                                slot_out_next = SLOT_W'(end_reg[IDX_W-1:0]);
                            end
                            else
                                status_next = STATUS_FULL;
                        end
                        REQ_READ:
                        begin
                            if (len_reg == '0 || !in_range)
                                status_next = STATUS_BAD;
                            else if (!rd_live)
                                status_next = STATUS_NOT_LIVE;
                            else
                                rdata_next = rd_payload & rmask;
                        end
                        REQ_UPDATE:
                        begin
                            if (len_reg > p_eff)
                                status_next = STATUS_TOO_LONG;
                            else if (!in_range)
                                status_next = STATUS_BAD;
                            else if (!rd_live)
                                status_next = STATUS_NOT_LIVE;
                            else
                                wr_en = 1'b1;
                        end
                        REQ_ERASE:
                        begin
                            if (!in_range)
                                status_next = STATUS_BAD;
                            else if (rd_live)
                            begin
                                // push onto the free list, keep the payload bits
                                wr_en          = 1'b1;
                                wr_word        = {1'b0, free_head_reg, rd_payload};
                                free_head_next = PTR_W'(slot_idx);
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_BAD;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pbytes_reg    <= PAYLOAD_BYTES_RST;
            free_head_reg <= '1;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            end_reg       <= end_next;
            if (cfg_wr)
                pbytes_reg <= pwdata[LEN_W-1:0];
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= status_next;
            slot_out_reg <= slot_out_next;
            rdata_reg    <= rdata_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign read_data = DATA_W'(rdata_reg);

`ifndef SYNTHESIS
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && !out_valid_reg |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("write-back did not complete with a free output register");

    a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg <= SLOT_LIMIT)
        else $error("append pointer past slot count");

    a_end_grows: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg != $past(end_reg) |-> end_reg == $past(end_reg) + 1'b1)
        else $error("append pointer moved by other than one");

    a_head_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg < end_reg) || (free_head_reg == '1))
        else $error("free-list head points at an unused slot");
`endif

endmodule

@@ tb/tb_fixed_slot_free_list_store_top.sv @@
`timescale 1ns / 1ps

module tb_fixed_slot_free_list_store_top;
    import fsfls_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [DATA_W-1:0]   read_data;
    } store_reply_t;

    // Tracks the slot store and its free list, and holds the replies still owed.
    class record_store_model;
        bit                  live[SLOT_COUNT_DEF];
        logic [8:0]          link[SLOT_COUNT_DEF];
        logic [DATA_W-1:0]   store[SLOT_COUNT_DEF];
        logic [8:0]          head;
        int                  used_end;
        logic [LEN_W-1:0]    pay_cfg;
        store_reply_t        replies[$];
        int                  mismatches;

        function new();
            head       = '1;
            used_end   = 0;
            pay_cfg    = PAYLOAD_BYTES_RST;
            mismatches = 0;
        endfunction

        function void set_payload_bytes(logic [LEN_W-1:0] v);
            pay_cfg = v;
        endfunction

        function int eff_bytes();
            return (pay_cfg < MAX_PAYLOAD_BYTES_DEF) ? int'(pay_cfg) : MAX_PAYLOAD_BYTES_DEF;
        endfunction

        function logic [DATA_W-1:0] low_bytes(logic [DATA_W-1:0] d, int n);
            if (n >= 8)
                return d;
            return d & ((64'd1 << (8 * n)) - 64'd1);
        endfunction

        function int pending();
            return replies.size();
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] s,
                                   logic [DATA_W-1:0] d, logic [LEN_W-1:0] len);
            int p;
            int pick;
            store_reply_t r;
            p = eff_bytes();
            r.status    = STATUS_OK;
            r.slot_out  = s;
            r.read_data = '0;
            case (req)
                REQ_INSERT: begin
                    r.slot_out = '0;
                    if (len > p) begin
                        r.status = STATUS_TOO_LONG;
                    end else begin
                        pick = -1;
                        if (head < SLOT_COUNT_DEF) begin
                            pick = int'(head);
                            head = link[pick];
                        end else if (used_end < SLOT_COUNT_DEF) begin
                            pick = used_end;
                            used_end++;
                        end else begin
                            r.status = STATUS_FULL;
                        end
                        if (pick >= 0) begin
                            live[pick]  = 1'b1;
                            store[pick] = low_bytes(d, int'(len));
                            r.slot_out  = pick[SLOT_W-1:0];
                        end
                    end
                end
                REQ_READ: begin
                    if (len == 0)
                        r.status = STATUS_BAD;
                    else if (s >= used_end)
                        r.status = STATUS_BAD;
                    else if (!live[s])
                        r.status = STATUS_NOT_LIVE;
                    else
                        r.read_data = low_bytes(store[s], (len > p) ? p : int'(len));
                end
                REQ_UPDATE: begin
                    if (len > p)
                        r.status = STATUS_TOO_LONG;
                    else if (s >= used_end)
                        r.status = STATUS_BAD;
                    else if (!live[s])
                        r.status = STATUS_NOT_LIVE;
                    else
                        store[s] = low_bytes(d, int'(len));
                end
                default: begin
                    if (s >= used_end) begin
                        r.status = STATUS_BAD;
                    end else if (live[s]) begin
                        live[s] = 1'b0;
                        link[s] = head;
                        head    = {1'b0, s};
                    end
                end
            endcase
            replies.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] so,
                                   logic [DATA_W-1:0] rd);
            store_reply_t e;
            if (replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status=%0d slot_out=%0d read_data=%h",
                             st, so, rd);
                return;
            end
            e = replies.pop_front();
            if (st !== e.status || so !== e.slot_out || rd !== e.read_data) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp status=%0d slot_out=%0d read_data=%h, ",
                              "got status=%0d slot_out=%0d read_data=%h"},
                             e.status, e.slot_out, e.read_data, st, so, rd);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [REQ_W-1:0]      req_type;
    logic [SLOT_W-1:0]     slot;
    logic [DATA_W-1:0]     data;
    logic [LEN_W-1:0]      length;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot_out;
    logic [DATA_W-1:0]     read_data;

    record_store_model model = new();
    bit                calm;
    int unsigned       cycle_count;
    int                stall_left;

    fixed_slot_free_list_store_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .slot      (slot),
        .data      (data),
        .length    (length),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .slot_out  (slot_out),
        .read_data (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("fixed_slot_free_list_store_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            model.note_request(req_type, slot, data, length);
        if (rst_n && out_valid && !out_stall)
            model.check_result(status, slot_out, read_data);
    end

    // Receiver side: random runs of stall and go, stall picked one time in three; hold go when calm.
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                out_stall  <= 1'b0;
                stall_left = 0;
            end
            else if (stall_left > 0)
                stall_left--;
            else if (rst_n && $urandom_range(0, 2) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(0, 7);
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end
        end
    end

    task automatic send_request(logic [REQ_W-1:0] rq, logic [SLOT_W-1:0] s,
                                logic [DATA_W-1:0] d, logic [LEN_W-1:0] ln);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 8))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= rq;
        slot     <= s;
        data     <= d;
        length   <= ln;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_payload_bytes(logic [APB_DATA_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_PAYLOAD_BYTES;
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model.set_payload_bytes(v[LEN_W-1:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random mix; slots lean toward the used region, lengths toward the legal size.
    task automatic run_phase(int n, int ins_pct, int era_pct);
        int               k;
        int               roll;
        int               p;
        logic [REQ_W-1:0] rq;
        logic [SLOT_W-1:0] s;
        logic [LEN_W-1:0] ln;
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                rq = REQ_INSERT;
            else if (roll < ins_pct + era_pct)
                rq = REQ_ERASE;
            else if (roll % 2 == 0)
                rq = REQ_READ;
            else
                rq = REQ_UPDATE;
            if (model.used_end > 0 && $urandom_range(0, 99) < 85)
                s = SLOT_W'($urandom_range(0, model.used_end - 1));
            else
                s = SLOT_W'($urandom_range(0, 255));
            p = model.eff_bytes();
            if ($urandom_range(0, 99) < 85)
                ln = LEN_W'($urandom_range(0, p));
            else
                ln = LEN_W'($urandom_range(0, 15));
            send_request(rq, s, {$urandom(), $urandom()}, ln);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        calm     = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        req_type = REQ_INSERT;
        slot     = '0;
        data     = '0;
        length   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty store: everything addressed is out of range
        send_request(REQ_READ,   8'd0,   64'd0, 4'd1);
        send_request(REQ_ERASE,  8'd255, 64'd0, 4'd0);
        send_request(REQ_UPDATE, 8'd0,   64'd0, 4'd0);
        // appends, zero padding, too long
        send_request(REQ_INSERT, 8'd7, '1, 4'd8);
        send_request(REQ_INSERT, 8'd0, '1, 4'd0);
        send_request(REQ_INSERT, 8'd0, 64'h1122334455667788, 4'd3);
        send_request(REQ_INSERT, 8'd0, '1, 4'd9);
        // zero-length read, clamped read, short read
        send_request(REQ_READ,   8'd0, 64'd0, 4'd0);
        send_request(REQ_READ,   8'd0, 64'd0, 4'd8);
        send_request(REQ_READ,   8'd0, 64'd0, 4'd15);
        send_request(REQ_READ,   8'd2, 64'd0, 4'd2);
        send_request(REQ_READ,   8'd1, 64'd0, 4'd8);
        // update: length is checked before the slot
        send_request(REQ_UPDATE, 8'd0,   '1, 4'd9);
        send_request(REQ_UPDATE, 8'd200, '1, 4'd15);
        send_request(REQ_UPDATE, 8'd0, 64'hA5C3_0F96_5A3C_F069, 4'd5);
        send_request(REQ_READ,   8'd0, 64'd0, 4'd8);
        // erase twice, then dead-slot access
        send_request(REQ_ERASE,  8'd0, 64'd0, 4'd0);
        send_request(REQ_ERASE,  8'd0, 64'd0, 4'd0);
        send_request(REQ_READ,   8'd0, 64'd0, 4'd4);
        send_request(REQ_UPDATE, 8'd0, 64'd0, 4'd1);
        // free list is LIFO, then append resumes
        send_request(REQ_ERASE,  8'd2, 64'd0, 4'd0);
        send_request(REQ_INSERT, 8'd0, 64'hFEDC_BA98_7654_3210, 4'd1);
        send_request(REQ_INSERT, 8'd0, 64'h0123_4567_89AB_CDEF, 4'd2);
        send_request(REQ_INSERT, 8'd0, 64'h8000_0000_0000_0001, 4'd8);
        send_request(REQ_READ,   8'd3, 64'd0, 4'd8);

        run_phase(60, 40, 15);
        drain();
        write_payload_bytes(32'd3);
        run_phase(200, 85, 6);
        drain();
        write_payload_bytes(32'd0);
        run_phase(60, 30, 20);
        drain();
        write_payload_bytes(32'd15);
        run_phase(200, 80, 8);
        drain();
        write_payload_bytes(32'd1);
        run_phase(60, 30, 30);
        drain();
        write_payload_bytes(32'd8);
        calm = 1'b1;
        run_phase(70, 35, 20);
        drain();
        repeat (20) @(posedge clk);

        if (model.mismatches == 0 && model.pending() == 0)
            $display("fixed_slot_free_list_store_top test passed");
        else
            $display("fixed_slot_free_list_store_top test failed");
        $finish;
    end

endmodule
